// ----- sv/lpd_pkg.sv -----
`default_nettype none

package lpd_pkg;

   localparam int unsigned MAX_PREFIX_BYTES = 12;
   localparam logic [4:0]  MAX_PREFIX_COUNT = 5'(MAX_PREFIX_BYTES);

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic        REG_PREFIX_FORMAT = 1'b0;

   localparam logic [3:0] FMT_U8        = 4'd0;
   localparam logic [3:0] FMT_U16_LE    = 4'd1;
   localparam logic [3:0] FMT_U24_LE    = 4'd2;
   localparam logic [3:0] FMT_U32_LE    = 4'd3;
   localparam logic [3:0] FMT_U16_BE    = 4'd4;
   localparam logic [3:0] FMT_U24_BE    = 4'd5;
   localparam logic [3:0] FMT_U32_BE    = 4'd6;
   localparam logic [3:0] FMT_VARINT_LE = 4'd7;
   localparam logic [3:0] FMT_VARINT_BE = 4'd8;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [1:0] STATUS_OK            = 2'd0;
   localparam logic [1:0] STATUS_BAD_PREFIX    = 2'd1;
   localparam logic [1:0] STATUS_END_IN_PREFIX = 2'd2;
   localparam logic [1:0] STATUS_END_IN_BODY   = 2'd3;

   typedef enum logic [1:0] {
      PH_PREFIX = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       record_end;
      logic [1:0] status;
   } rsp_word_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

`default_nettype wire

// ----- sv/lpd_req_if.sv -----
`default_nettype none

interface lpd_req_if ();
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/lpd_rsp_if.sv -----
`default_nettype none

interface lpd_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       byte_valid;
   logic       record_end;
   logic [1:0] status;

   modport source (output valid, output payload_byte, output byte_valid,
                   output record_end, output status, input ready);
   modport sink   (input valid, input payload_byte, input byte_valid,
                   input record_end, input status, output ready);
endinterface

`default_nettype wire

// ----- sv/lpd_csr.sv -----
`default_nettype none

module lpd_csr import lpd_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output logic [3:0]                     prefix_format
);

   logic [3:0] format_ff;
   logic [3:0] format_in;
   logic       reg_index;

   assign reg_index  = csr_paddr[CSR_ADDR_WIDTH-1];
   assign csr_pready = 1'b1;

   always_comb begin
      format_in = format_ff;
      if (csr_psel && csr_penable && csr_pwrite && (reg_index == REG_PREFIX_FORMAT)) begin
         format_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_U8;
      end else begin
         format_ff <= format_in;
      end
   end

   assign csr_prdata    = (reg_index == REG_PREFIX_FORMAT) ? {28'd0, format_ff} : 32'd0;
   assign prefix_format = format_ff;

endmodule

`default_nettype wire

// ----- sv/lpd_parse.sv -----
`default_nettype none

module lpd_parse import lpd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   [3:0] prefix_format,
   input  wire logic   load,
   input  wire logic   load_cmd,
   input  wire logic   [7:0] load_byte,
   input  wire logic   advance,
   output logic        in_valid,
   output logic        res_valid,
   output rsp_word_type res_word
);

   logic       in_valid_ff, in_valid_in;
   logic       cmd_ff;
   logic [7:0] byte_ff;

   phase_type  phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] remain_ff, remain_in;

   logic        fire;
   logic        emit;
   logic [6:0]  grp;
   logic        last_group;
   logic        is_varint;
   logic [2:0]  fixed_len;
   logic        fixed_le;
   logic [3:0]  count_inc;
   logic [31:0] le_shifted;
   logic        le_err;
   logic [31:0] vint_accum;
   logic        vint_err;
   logic        too_long;
   logic [31:0] byte_shifted;
   logic [31:0] fixed_accum;
   logic [31:0] new_accum;
   logic        pre_data;
   logic        raise;
   logic        done;
   logic        len_zero;
   logic [31:0] remain_dec;
   logic        body_last;

   assign fire        = in_valid_ff && advance;
   assign in_valid_in = load || (in_valid_ff && !advance);
   assign in_valid    = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_PREFIX;
         count_ff    <= 4'd0;
         accum_ff    <= 32'd0;
         remain_ff   <= 32'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         accum_ff    <= accum_in;
         remain_ff   <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff  <= load_cmd;
         byte_ff <= load_byte;
      end
   end

   // Prefix datapath for the word held in the input register.
   always_comb begin
      grp        = byte_ff[6:0];
      last_group = !byte_ff[7];
      is_varint  = (prefix_format == FMT_VARINT_LE) || (prefix_format == FMT_VARINT_BE);
      count_inc  = count_ff + 4'd1;

      unique case (prefix_format)
         FMT_U16_LE, FMT_U16_BE: fixed_len = 3'd2;
         FMT_U24_LE, FMT_U24_BE: fixed_len = 3'd3;
         FMT_U32_LE, FMT_U32_BE: fixed_len = 3'd4;
         default:                fixed_len = 3'd1;
      endcase
      fixed_le = (prefix_format == FMT_U16_LE) || (prefix_format == FMT_U24_LE)
              || (prefix_format == FMT_U32_LE);

      le_err = 1'b0;
      unique case (count_ff)
         4'd0: le_shifted = {25'd0, grp};
         4'd1: le_shifted = {18'd0, grp, 7'd0};
         4'd2: le_shifted = {11'd0, grp, 14'd0};
         4'd3: le_shifted = {4'd0, grp, 21'd0};
         4'd4: begin
            le_shifted = {grp[3:0], 28'd0};
            le_err     = |grp[6:4];
         end
         default: begin
            le_shifted = 32'd0;
            le_err     = |grp;
         end
      endcase

      if (prefix_format == FMT_VARINT_LE) begin
         vint_accum = accum_ff | le_shifted;
         vint_err   = le_err;
      end else begin
         vint_accum = {accum_ff[24:0], grp};
         vint_err   = |accum_ff[31:25];
      end
      too_long = ({1'b0, count_ff} + 5'd1) >= MAX_PREFIX_COUNT;

      unique case (count_ff[1:0])
         2'd0: byte_shifted = {24'd0, byte_ff};
         2'd1: byte_shifted = {16'd0, byte_ff, 8'd0};
         2'd2: byte_shifted = {8'd0, byte_ff, 16'd0};
         default: byte_shifted = {byte_ff, 24'd0};
      endcase
      if (fixed_le) begin
         fixed_accum = (count_ff < 4'd4) ? (accum_ff | byte_shifted) : accum_ff;
      end else begin
         fixed_accum = {accum_ff[23:0], byte_ff};
      end

      new_accum  = is_varint ? vint_accum : fixed_accum;
      pre_data   = (phase_ff == PH_PREFIX) && (cmd_ff == CMD_DATA);
      raise      = pre_data && is_varint && (vint_err || (!last_group && too_long));
      done       = pre_data && !raise
                && (is_varint ? last_group : (count_inc >= {1'b0, fixed_len}));
      len_zero   = (new_accum == 32'd0);
      remain_dec = remain_ff - 32'd1;
      body_last  = (remain_dec == 32'd0);
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      accum_in  = accum_ff;
      remain_in = remain_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if (cmd_ff == CMD_DATA) begin
                  if (raise) begin
                     phase_in = PH_ERROR;
                     count_in = 4'd0;
                     accum_in = 32'd0;
                  end else if (done) begin
                     count_in = 4'd0;
                     accum_in = 32'd0;
                     if (!len_zero) begin
                        remain_in = new_accum;
                        phase_in  = PH_BODY;
                     end
                  end else begin
                     count_in = count_inc;
                     accum_in = new_accum;
                  end
               end
            end
            PH_BODY: begin
               if (cmd_ff == CMD_DATA) begin
                  remain_in = remain_dec;
                  if (body_last) begin
                     phase_in = PH_PREFIX;
                     count_in = 4'd0;
                     accum_in = 32'd0;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      emit     = 1'b0;
      res_word = '0;
      unique case (phase_ff)
         PH_PREFIX: begin
            if (cmd_ff == CMD_END) begin
               emit            = 1'b1;
               res_word.status = (count_ff != 4'd0) ? STATUS_END_IN_PREFIX : STATUS_OK;
            end else if (raise) begin
               emit            = 1'b1;
               res_word.status = STATUS_BAD_PREFIX;
            end else if (done && len_zero) begin
               emit                = 1'b1;
               res_word.record_end = 1'b1;
            end
         end
         PH_BODY: begin
            emit = 1'b1;
            if (cmd_ff == CMD_END) begin
               res_word.status = STATUS_END_IN_BODY;
            end else begin
               res_word.payload_byte = byte_ff;
               res_word.byte_valid   = 1'b1;
               res_word.record_end   = body_last;
            end
         end
         default: begin
            emit            = 1'b1;
            res_word.status = STATUS_BAD_PREFIX;
         end
      endcase
   end

   assign res_valid = fire && emit;

endmodule

`default_nettype wire

// ----- sv/lpd_out_buf.sv -----
`default_nettype none

module lpd_out_buf import lpd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_word_type  push_word,
   output buf_status_type     buf_status,
   lpd_rsp_if.source          rsp_chan
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type main_ff, main_in;
   rsp_word_type skid_ff, skid_in;
   logic         pop;

   assign pop = main_valid_ff && rsp_chan.ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = main_valid_ff;
   assign rsp_chan.payload_byte = main_ff.payload_byte;
   assign rsp_chan.byte_valid   = main_ff.byte_valid;
   assign rsp_chan.record_end   = main_ff.record_end;
   assign rsp_chan.status       = main_ff.status;

   assign buf_status.main_valid = main_valid_ff;
   assign buf_status.skid_valid = skid_valid_ff;

endmodule

`default_nettype wire

// ----- sv/length_prefix_deframer.sv -----
// Channel     Direction  Payload                                          Handshake
// req_chan    in         cmd, data_byte                                   valid/ready
// rsp_chan    out        payload_byte, byte_valid, record_end, status     valid/ready
// csr_*       in/out     prefix_format at byte address 0                  APB, pready high
//
// A word is accepted every cycle unless the output buffer is full; its result, if any, is
// registered in the output buffer. The prefix and length update is combinational.
// Reset is synchronous and clears the phase, the prefix state and all valid flags.
// A two-entry output buffer absorbs one stalled result; input stalls only when it is full.
`default_nettype none

module length_prefix_deframer import lpd_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   lpd_req_if.sink                        req_chan,
   lpd_rsp_if.source                      rsp_chan,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   logic           [3:0] prefix_format;
   logic           in_valid;
   logic           advance;
   logic           accept;
   logic           res_valid;
   rsp_word_type   res_word;
   buf_status_type buf_status;

   assign advance        = !buf_status.skid_valid;
   assign req_chan.ready = !in_valid || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   lpd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .prefix_format (prefix_format)
   );

   lpd_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .prefix_format (prefix_format),
      .load          (accept),
      .load_cmd      (req_chan.cmd),
      .load_byte     (req_chan.data_byte),
      .advance       (advance),
      .in_valid      (in_valid),
      .res_valid     (res_valid),
      .res_word      (res_word)
   );

   lpd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_word  (res_word),
      .buf_status (buf_status),
      .rsp_chan   (rsp_chan)
   );

   a_skid_needs_main : assert property (@(posedge clock) disable iff (reset)
      buf_status.skid_valid |-> buf_status.main_valid)
      else $error("skid entry held while output register is empty");

   a_stalled_word_kept : assert property (@(posedge clock) disable iff (reset)
      (in_valid && buf_status.skid_valid) |=> in_valid)
      else $error("input word lost while output buffer was full");

   a_payload_status_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.byte_valid) |-> (rsp_chan.status == STATUS_OK))
      else $error("payload word carries an error status");

   a_marker_status_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.record_end) |-> (rsp_chan.status == STATUS_OK))
      else $error("record end carries an error status");

endmodule

`default_nettype wire
